@@ src/hbwd_pkg.sv @@
// Shared types, codes and sizing constants of the heartbeat watchdog.
package hbwd_pkg;

  // Fixed field widths
  localparam int CMD_W    = 3;
  localparam int CHF_W    = 4;
  localparam int MASK_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int MAX_CH_W = 6;   // channel index width at the largest table size

  // Defaults
  localparam int DEF_CHANNELS   = 16;
  localparam int CMDQ_DEPTH     = 4;
  localparam int OUTQ_DEPTH     = 4;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

  // Command codes as they arrive on the input
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACK        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd5;

  // Classified operations handed to the back end
  typedef enum logic [2:0] {
    OP_REG   = 3'd0,
    OP_UNREG = 3'd1,
    OP_ACK   = 3'd2,
    OP_TICK  = 3'd3,
    OP_START = 3'd4,
    OP_STOP  = 3'd5,
    OP_NOP   = 3'd6
  } op_t;

  // Channel status codes
  localparam logic [1:0] ST_CHECKED = 2'd0;
  localparam logic [1:0] ST_AWAIT   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PING    = 3'd1,
    EV_BLOCK   = 3'd2,
    EV_RECOVER = 3'd3,
    EV_REFUSED = 3'd4
  } ev_code_t;

  typedef struct packed {
    op_t               op;
    logic [MAX_CH_W-1:0] ch;
    logic [MASK_W-1:0] mask;
  } cmd_t;

  typedef struct packed {
    ev_code_t         ev;
    logic [CHF_W-1:0] ch;
    logic             last;
  } ev_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_CMD  = 2'd1,
    B_SCAN = 2'd2,
    B_FIN  = 2'd3
  } bstate_t;

endpackage

@@ src/hbwd_fifo.sv @@
// Small register-based queue used between front, back and result ports.
module hbwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/hbwd_front.sv @@
// Front end: accepts commands and classifies them into back-end operations.
module hbwd_front import hbwd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic              in_push,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CHF_W-1:0]  in_channel,
  input  logic [MASK_W-1:0] in_running_mask,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_data
);

  logic ch_ok;

  assign ch_ok   = ((MAX_CH_W+1)'(in_channel) < (MAX_CH_W+1)'(CHANNELS));
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_data.ch   = MAX_CH_W'(in_channel);
    q_data.mask = in_running_mask;
    case (in_command)
      CMD_REGISTER:   q_data.op = ch_ok ? OP_REG : OP_NOP;
      CMD_UNREGISTER: q_data.op = ch_ok ? OP_UNREG : OP_NOP;
      CMD_ACK:        q_data.op = ch_ok ? OP_ACK : OP_NOP;
      CMD_TICK:       q_data.op = OP_TICK;
      CMD_START:      q_data.op = OP_START;
      CMD_STOP:       q_data.op = OP_STOP;
      default:        q_data.op = OP_NOP;
    endcase
  end

endmodule

@@ src/hbwd_back.sv @@
// Back end: channel table, tick counter and round scanner.
module hbwd_back import hbwd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                q_empty,
  input  cmd_t                q_head,
  output logic                q_pop,
  input  logic                ev_full,
  output logic                ev_push,
  output ev_t                 ev_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  bstate_t             state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [CH_W-1:0]     idx_r, idx_nxt;
  logic [CHANNELS-1:0] valid_r, valid_nxt;
  logic                enabled_r, enabled_nxt;
  logic [PERIOD_W-1:0] tick_r, tick_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic                pend_v_r, pend_v_nxt;
  ev_code_t            pend_ev_r, pend_ev_nxt;
  logic [CHF_W-1:0]    pend_ch_r, pend_ch_nxt;

  logic [1:0]          status_mem [CHANNELS];
  logic [1:0]          rd_r;
  logic [CH_W-1:0]     raddr, waddr;
  logic                mem_we;
  logic [1:0]          wdata;

  logic [PERIOD_W:0]   lim, tick_n;
  logic                go_scan;
  logic [MAX_CH_W-1:0] idx_w;
  logic                run, new_ev, blocked;
  ev_code_t            new_code;
  logic [1:0]          new_st;
  logic                st_we;

  assign lim    = (period_r == '0) ? (PERIOD_W+1)'(1) : (PERIOD_W+1)'(period_r);
  assign tick_n = (PERIOD_W+1)'(tick_r) + 1'b1;
  assign idx_w  = MAX_CH_W'(idx_r);
  assign run    = (idx_w < MAX_CH_W'(MASK_W)) && mask_r[idx_w[3:0]];

  // Scan decision for the channel under the scan index
  always_comb begin
    new_ev   = 1'b0;
    new_code = EV_NONE;
    new_st   = rd_r;
    st_we    = 1'b0;
    if (valid_r[idx_r]) begin
      if (rd_r == ST_AWAIT) begin
        new_st   = ST_TIMEOUT;
        st_we    = 1'b1;
        new_ev   = 1'b1;
        new_code = EV_BLOCK;
      end else if (rd_r != ST_TIMEOUT) begin
        new_st = run ? ST_AWAIT : ST_CHECKED;
        st_we  = 1'b1;
        if (run) begin
          new_ev   = 1'b1;
          new_code = EV_PING;
        end
      end
    end
  end

  assign blocked = new_ev && pend_v_r && ev_full;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    mask_nxt    = mask_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    enabled_nxt = enabled_r;
    tick_nxt    = tick_r;
    pend_v_nxt  = pend_v_r;
    pend_ev_nxt = pend_ev_r;
    pend_ch_nxt = pend_ch_r;
    raddr       = CH_W'(q_head.ch);
    waddr       = idx_r;
    wdata       = ST_CHECKED;
    mem_we      = 1'b0;
    q_pop       = 1'b0;
    ev_push     = 1'b0;
    ev_data     = '{ev: pend_ev_r, ch: pend_ch_r, last: 1'b0};
    go_scan     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          op_nxt    = q_head.op;
          ch_nxt    = CH_W'(q_head.ch);
          mask_nxt  = q_head.mask;
          state_nxt = B_CMD;
        end
      end
      B_CMD: begin
        waddr = ch_r;
        case (op_r)
          OP_REG: begin
            if (!valid_r[ch_r]) begin
              valid_nxt[ch_r] = 1'b1;
              mem_we          = 1'b1;
            end
          end
          OP_UNREG: begin
            valid_nxt[ch_r] = 1'b0;
            mem_we          = 1'b1;
          end
          OP_ACK: begin
            if (valid_r[ch_r]) begin
              mem_we = 1'b1;
              if (rd_r == ST_TIMEOUT) begin
                pend_v_nxt  = 1'b1;
                pend_ev_nxt = EV_RECOVER;
                pend_ch_nxt = CHF_W'(ch_r);
              end
            end
          end
          OP_TICK: begin
            if (enabled_r) begin
              if (tick_n >= lim) begin
                tick_nxt = '0;
                go_scan  = 1'b1;
              end else begin
                tick_nxt = tick_n[PERIOD_W-1:0];
              end
            end
          end
          OP_START: begin
            if (enabled_r) begin
              pend_v_nxt  = 1'b1;
              pend_ev_nxt = EV_REFUSED;
              pend_ch_nxt = '0;
            end else begin
              enabled_nxt = 1'b1;
              tick_nxt    = '0;
              go_scan     = 1'b1;
            end
          end
          OP_STOP: begin
            if (!enabled_r) begin
              pend_v_nxt  = 1'b1;
              pend_ev_nxt = EV_REFUSED;
              pend_ch_nxt = '0;
            end else begin
              valid_nxt   = '0;
              tick_nxt    = '0;
              enabled_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (go_scan) begin
          idx_nxt   = '0;
          raddr     = '0;
          state_nxt = B_SCAN;
        end else begin
          state_nxt = B_FIN;
        end
      end
      B_SCAN: begin
        raddr = idx_r;
        if (!blocked) begin
          waddr  = idx_r;
          wdata  = new_st;
          mem_we = st_we;
          if (new_ev) begin
            ev_push     = pend_v_r;
            pend_v_nxt  = 1'b1;
            pend_ev_nxt = new_code;
            pend_ch_nxt = CHF_W'(idx_r);
          end
          if (idx_r == CH_W'(CHANNELS-1)) begin
            state_nxt = B_FIN;
          end else begin
            idx_nxt = CH_W'(idx_r + 1'b1);
            raddr   = CH_W'(idx_r + 1'b1);
          end
        end
      end
      B_FIN: begin
        ev_data.last = 1'b1;
        if (!pend_v_r) begin
          ev_data.ev = EV_NONE;
          ev_data.ch = '0;
        end
        if (!ev_full) begin
          ev_push    = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      valid_r   <= '0;
      enabled_r <= 1'b0;
      tick_r    <= '0;
      pend_v_r  <= 1'b0;
      period_r  <= PERIOD_RESET;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      enabled_r <= enabled_nxt;
      tick_r    <= tick_nxt;
      pend_v_r  <= pend_v_nxt;
      if (cfg_we) begin
        period_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    mask_r    <= mask_nxt;
    idx_r     <= idx_nxt;
    pend_ev_r <= pend_ev_nxt;
    pend_ch_r <= pend_ch_nxt;
  end

  // Status table; entries are only read behind a set valid bit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      status_mem[waddr] <= wdata;
    end
    rd_r <= status_mem[raddr];
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !ev_full)
    else $error("event pushed into a full result queue");

  a_stop_only: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(enabled_r) |-> $past(state_r == B_CMD && op_r == OP_STOP))
    else $error("watchdog disabled without a stop command");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |-> (MAX_CH_W+1)'(idx_r) < (MAX_CH_W+1)'(CHANNELS))
    else $error("scan index beyond the table");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_push && ev_data.last) |=> (state_r == B_IDLE))
    else $error("final result pushed but back end did not return to idle");

endmodule

@@ src/multi_channel_heartbeat_watchdog_core.sv @@
// Top level of the multi-channel heartbeat watchdog.
// Usage:
//   Input channel is a queue write port: present in_command, in_channel and
//   in_running_mask with in_push; the transfer happens when in_full is low.
//   Results come out of a queue read port: while out_empty is low the oldest
//   event is on out_event_res/out_event_channel/out_last; pulse out_pop to
//   take it. Every command yields one or more events, out_last marks the end.
//   The cfg_ channel writes period_ticks; cfg_ready is always high.
// Timing:
//   A command passes a 4-deep command queue, then the back end takes it through
//   dequeue, table access and final push for register, unregister, ack, stop
//   or a tick that does not end a period. A start or a period-end tick adds a
//   scan of all CHANNELS entries, one table entry per cycle while the scan is
//   not stalled by a full result queue. A round holds each event back until
//   the next one is found, so its results trail.
// Reset and stall:
//   Synchronous active-low reset empties both queues, clears the table valid
//   bits, the tick count and the enable, and loads period_ticks with 10.
//   A stalled receiver fills the 4-deep result queue, the scanner holds on the
//   current channel, the command queue backs up and in_full rises; none is lost.
module multi_channel_heartbeat_watchdog_core import hbwd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst_n,
  // command input
  input  logic                in_push,
  output logic                in_full,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [CHF_W-1:0]    in_channel,
  input  logic [MASK_W-1:0]   in_running_mask,
  // event output
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_event_res,
  output logic [CHF_W-1:0]    out_event_channel,
  output logic                out_last,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  logic cq_full, cq_push, cq_empty, cq_pop;
  cmd_t cq_wdata, cq_rdata;
  logic eq_full, eq_push, eq_empty;
  ev_t  eq_wdata, eq_rdata;

  // Configuration is always accepted
  assign cfg_ready = 1'b1;

  // Classify incoming commands
  hbwd_front #(.CHANNELS(CHANNELS)) u_front (
    .in_push         (in_push),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_running_mask (in_running_mask),
    .in_full         (in_full),
    .q_full          (cq_full),
    .q_push          (cq_push),
    .q_data          (cq_wdata)
  );

  // Decouple front and back
  hbwd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  // Execute commands and run rounds
  hbwd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .q_empty  (cq_empty),
    .q_head   (cq_rdata),
    .q_pop    (cq_pop),
    .ev_full  (eq_full),
    .ev_push  (eq_push),
    .ev_data  (eq_wdata)
  );

  // Hold results until the receiver takes them
  hbwd_fifo #(.WIDTH($bits(ev_t)), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (eq_push),
    .wdata (eq_wdata),
    .full  (eq_full),
    .pop   (out_pop),
    .rdata (eq_rdata),
    .empty (eq_empty)
  );

  assign out_empty         = eq_empty;
  assign out_event_res     = eq_rdata.ev;
  assign out_event_channel = eq_rdata.ch;
  assign out_last          = eq_rdata.last;

endmodule

@@ bench/tb_multi_channel_heartbeat_watchdog_core.sv @@
// Self-checking testbench for the multi-channel heartbeat watchdog core.
`timescale 1ns / 100ps

module tb_multi_channel_heartbeat_watchdog_core import hbwd_pkg::*;;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off for back-pressure
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 58;

  // Period per random phase: reset value, extremes, zero (acts as one), small values
  localparam logic [PERIOD_W-1:0] PHASE_PERIOD [PHASES] =
    '{16'd10, 16'd1, 16'd65535, 16'd3, 16'd0, 16'd2};
  // Idling per phase: phase 1 is the back-pressure phase, phase 3 runs at full rate
  localparam bit TX_IDLE_OF [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam bit RX_IDLE_OF [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_push         = 1'b0;
  logic                in_full;
  logic [CMD_W-1:0]    in_command      = '0;
  logic [CHF_W-1:0]    in_channel      = '0;
  logic [MASK_W-1:0]   in_running_mask = '0;
  logic                out_empty;
  logic                out_pop         = 1'b0;
  logic [2:0]          out_event_res;
  logic [CHF_W-1:0]    out_event_channel;
  logic                out_last;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data        = '0;

  // Watchdog mirror: table, tick counter, enable and period
  logic [DEF_CHANNELS-1:0] wd_valid;
  logic [1:0]              wd_status [DEF_CHANNELS];
  logic [15:0]             wd_ticks;
  logic                    wd_enabled;
  logic [PERIOD_W-1:0]     wd_period;

  ev_t new_events[$];       // events caused by the command being predicted
  ev_t pending_events[$];   // events still owed by the block, oldest first

  int fault_count = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  bit rx_hold     = 1'b0;

  // Directed rows: expected event typed in only where it is plain
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHF_W-1:0]  ch;
    logic [MASK_W-1:0] mask;
    logic              typed;
    ev_code_t          ev;
  } drive_row_t;

  localparam int DIRECTED_ROWS = 25;
  drive_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_STOP,       4'd0,  16'h0000, 1'b1, EV_REFUSED},  // stop while idle
    '{CMD_TICK,       4'd0,  16'hFFFF, 1'b1, EV_NONE},     // tick while idle
    '{CMD_ACK,        4'd5,  16'h0000, 1'b1, EV_NONE},     // ack to unknown channel
    '{CMD_SPARE6,     4'd9,  16'hAAAA, 1'b1, EV_NONE},
    '{CMD_SPARE7,     4'd15, 16'hFFFF, 1'b1, EV_NONE},
    '{CMD_REGISTER,   4'd0,  16'h0000, 1'b1, EV_NONE},
    '{CMD_REGISTER,   4'd15, 16'h0000, 1'b1, EV_NONE},
    '{CMD_REGISTER,   4'd7,  16'h0000, 1'b1, EV_NONE},
    '{CMD_REGISTER,   4'd7,  16'h0000, 1'b1, EV_NONE},     // already present
    '{CMD_UNREGISTER, 4'd3,  16'h0000, 1'b1, EV_NONE},     // not present
    '{CMD_ACK,        4'd7,  16'h0000, 1'b1, EV_NONE},     // ack while idle
    '{CMD_START,      4'd0,  16'hFFFF, 1'b0, EV_NONE},     // pings 0, 7, 15
    '{CMD_START,      4'd0,  16'hFFFF, 1'b1, EV_REFUSED},  // start while running
    '{CMD_ACK,        4'd7,  16'h0000, 1'b1, EV_NONE},
    '{CMD_TICK,       4'd0,  16'h0000, 1'b0, EV_NONE},     // blocks on 0 and 15
    '{CMD_TICK,       4'd0,  16'hFFFF, 1'b0, EV_NONE},
    '{CMD_ACK,        4'd15, 16'h0000, 1'b0, EV_NONE},     // recover 15
    '{CMD_TICK,       4'd0,  16'h8000, 1'b0, EV_NONE},
    '{CMD_UNREGISTER, 4'd0,  16'h0000, 1'b1, EV_NONE},
    '{CMD_ACK,        4'd0,  16'h0000, 1'b1, EV_NONE},
    '{CMD_TICK,       4'd0,  16'h5555, 1'b0, EV_NONE},
    '{CMD_STOP,       4'd0,  16'h0000, 1'b1, EV_NONE},
    '{CMD_TICK,       4'd0,  16'hFFFF, 1'b1, EV_NONE},
    '{CMD_START,      4'd0,  16'hFFFF, 1'b0, EV_NONE},     // empty table
    '{CMD_STOP,       4'd0,  16'h0000, 1'b1, EV_NONE}
  };

  multi_channel_heartbeat_watchdog_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_channel        (in_channel),
    .in_running_mask   (in_running_mask),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_event_res     (out_event_res),
    .out_event_channel (out_event_channel),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin : watchdog_timer
    #7_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Append one event to the batch of the command being predicted
  function automatic void note_event(input ev_code_t code, input logic [CHF_W-1:0] ch);
    ev_t item;
    item.ev    = code;
    item.ch    = ch;
    item.last  = 1'b0;
    new_events = {new_events, item};
  endfunction

  // One round: awaiting channels time out and checked running channels get pinged.
  // Scan in ascending channel order, at most one event per channel.
  function automatic void run_round(input logic [MASK_W-1:0] mask);
    for (int c = 0; c < DEF_CHANNELS; c++) begin
      if (wd_valid[c]) begin
        if (wd_status[c] == ST_AWAIT) begin
          wd_status[c] = ST_TIMEOUT;
          note_event(EV_BLOCK, CHF_W'(c));
        end else if (wd_status[c] != ST_TIMEOUT) begin
          wd_status[c] = mask[c] ? ST_AWAIT : ST_CHECKED;
          if (mask[c]) note_event(EV_PING, CHF_W'(c));
        end
      end
    end
  endfunction

  // Advance the mirror by one command and collect the events it causes
  function automatic void predict_events(input logic [CMD_W-1:0] cmd,
                                         input logic [CHF_W-1:0] ch,
                                         input logic [MASK_W-1:0] mask);
    logic [16:0] next_count;
    logic [16:0] limit;
    ev_t         tail;
    new_events.delete();
    case (cmd)
      CMD_REGISTER: begin
        if (!wd_valid[ch]) begin
          wd_valid[ch]  = 1'b1;
          wd_status[ch] = ST_CHECKED;
        end
      end
      CMD_UNREGISTER: begin
        wd_valid[ch]  = 1'b0;
        wd_status[ch] = ST_CHECKED;
      end
      CMD_ACK: begin
        if (wd_valid[ch]) begin
          if (wd_status[ch] == ST_TIMEOUT) note_event(EV_RECOVER, ch);
          wd_status[ch] = ST_CHECKED;
        end
      end
      CMD_TICK: begin
        if (wd_enabled) begin
          limit      = (wd_period == '0) ? 17'd1 : {1'b0, wd_period};
          next_count = {1'b0, wd_ticks} + 17'd1;
          if (next_count >= limit) begin
            wd_ticks = '0;
            run_round(mask);
          end else begin
            wd_ticks = next_count[15:0];
          end
        end
      end
      CMD_START: begin
        if (wd_enabled) begin
          note_event(EV_REFUSED, '0);
        end else begin
          wd_enabled = 1'b1;
          wd_ticks   = '0;
          run_round(mask);
        end
      end
      CMD_STOP: begin
        if (!wd_enabled) begin
          note_event(EV_REFUSED, '0);
        end else begin
          wd_valid = '0;
          foreach (wd_status[c]) wd_status[c] = ST_CHECKED;
          wd_ticks   = '0;
          wd_enabled = 1'b0;
        end
      end
      default: ;
    endcase
    // A quiet command still answers with a single none event; flag the final one
    if (new_events.size() == 0) note_event(EV_NONE, '0);
    tail       = new_events.pop_back();
    tail.last  = 1'b1;
    new_events = {new_events, tail};
  endfunction

  // Random command, weighted by the mirror so most traffic reaches running rounds
  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!wd_enabled) begin
      if (roll < 30) return CMD_START;
      if (roll < 60) return CMD_REGISTER;
      if (roll < 70) return CMD_ACK;
      if (roll < 80) return CMD_UNREGISTER;
      if (roll < 90) return CMD_TICK;
      if (roll < 95) return CMD_STOP;
      return roll[0] ? CMD_SPARE7 : CMD_SPARE6;
    end
    if (wd_valid == '0 && roll < 40) return CMD_REGISTER;
    if (roll < 45) return CMD_TICK;
    if (roll < 70) return CMD_ACK;
    if (roll < 80) return CMD_REGISTER;
    if (roll < 86) return CMD_UNREGISTER;
    if (roll < 91) return CMD_START;
    if (roll < 95) return CMD_STOP;
    return roll[0] ? CMD_SPARE7 : CMD_SPARE6;
  endfunction

  // Write period_ticks; call only with nothing in flight
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    wd_period = value;
  endtask

  // Offer one command, wait for its transfer, book the events it owes, then idle.
  // Keep in_push high across back-to-back commands so it is never dropped and
  // raised in the same step.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [CHF_W-1:0] ch,
                               input logic [MASK_W-1:0] mask, input bit typed,
                               input ev_code_t typed_ev);
    int  gap;
    ev_t typed_res;
    in_command      <= cmd;
    in_channel      <= ch;
    in_running_mask <= mask;
    in_push         <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    predict_events(cmd, ch, mask);
    if (typed) begin
      typed_res.ev   = typed_ev;
      typed_res.ch   = '0;
      typed_res.last = 1'b1;
      pending_events = {pending_events, typed_res};
    end else begin
      pending_events = {pending_events, new_events};
    end
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly well-formed traffic: acks aimed at registered channels, masks
  // biased to all-running or none-running now and then
  task automatic run_random_phase(input int items, input bit with_hold);
    logic [CMD_W-1:0]  cmd;
    logic [CHF_W-1:0]  ch;
    logic [MASK_W-1:0] mask;
    int unsigned       roll;
    for (int i = 0; i < items; i++) begin
      cmd = pick_command();
      ch  = CHF_W'($urandom_range(0, 15));
      if (cmd == CMD_ACK && wd_valid != '0 && $urandom_range(0, 3) != 0)
        while (!wd_valid[ch]) ch = CHF_W'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 15)      mask = 16'hFFFF;
      else if (roll < 25) mask = 16'h0000;
      else                mask = MASK_W'($urandom_range(0, 65535));
      // Freeze the receiver while commands keep coming, so both queues fill
      if (with_hold && i == 6) rx_hold = 1'b1;
      issue_command(cmd, ch, mask, 1'b0, EV_NONE);
    end
  endtask

  // Result side: pop with random stalls and compare each transfer with the
  // oldest owed event
  initial begin : event_sink
    int  stall;
    ev_t expected;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_pop <= 1'b1;
    forever begin
      do @(posedge clk); while (out_empty !== 1'b0);
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_res %0d event_channel %0d last %0d",
               out_event_res, out_event_channel, out_last);
        fault_count++;
      end else begin
        expected = pending_events.pop_front();
        if (out_event_res !== expected.ev) begin
          $error("event_res: expected %0d, got %0d", expected.ev, out_event_res);
          fault_count++;
        end
        if (out_event_channel !== expected.ch) begin
          $error("event_channel: expected %0d, got %0d", expected.ch, out_event_channel);
          fault_count++;
        end
        if (out_last !== expected.last) begin
          $error("last: expected %0d, got %0d", expected.last, out_last);
          fault_count++;
        end
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (rx_hold) begin
        rx_hold = 1'b0;
        stall   = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int drain_wait;
    // Mirror starts from the reset state of the block
    wd_valid   = '0;
    foreach (wd_status[c]) wd_status[c] = ST_CHECKED;
    wd_ticks   = '0;
    wd_enabled = 1'b0;
    wd_period  = PERIOD_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass runs with period zero, so every running tick is a round
    write_period(16'd0);
    foreach (directed_rows[r])
      issue_command(directed_rows[r].cmd, directed_rows[r].ch, directed_rows[r].mask,
                    directed_rows[r].typed, directed_rows[r].ev);

    for (int p = 0; p < PHASES; p++) begin
      // Hold the sender until every owed event is in, then retune the period
      in_push <= 1'b0;
      while (pending_events.size() != 0) @(posedge clk);
      @(posedge clk);
      write_period(PHASE_PERIOD[p]);
      tx_idle = TX_IDLE_OF[p];
      rx_idle = RX_IDLE_OF[p];
      run_random_phase(PHASE_ITEMS, p == 1);
    end
    in_push <= 1'b0;

    // Drain, then give the block time to show any stray event
    drain_wait = 0;
    while (pending_events.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (DEF_CHANNELS + 8) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      fault_count++;
    end

    if (fault_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
